FILE: sv/nsp_pkg.sv
`timescale 1ns / 1ps

package nsp_pkg;

	localparam int MAX_LEN_DIGITS = 9;
	localparam int DIGIT_CNT_W    = 4;
	localparam int LEN_W          = 30;
	localparam int CODE_W         = 64;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [1:0] {
		KIND_BYTE,
		KIND_DONE,
		KIND_ERR
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_TOO_LONG,
		ST_NO_COLON,
		ST_TOO_SHORT,
		ST_NO_COMMA,
		ST_LEAD_ZERO,
		ST_NO_LENGTH,
		ST_BAD_CODE
	} status_t;

	typedef struct packed {
		logic       is_digit;
		logic       is_colon;
		logic       is_comma;
		logic       is_space;
		logic [3:0] digit;
	} byte_class_t;

endpackage

FILE: sv/nsp_in_if.sv
`timescale 1ns / 1ps

interface nsp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       buffer_end;

	modport source (output valid, output in_byte, output buffer_end, input ready);
	modport sink (input valid, input in_byte, input buffer_end, output ready);
endinterface

FILE: sv/nsp_out_if.sv
`timescale 1ns / 1ps

interface nsp_out_if;
	import nsp_pkg::*;

	logic              valid;
	logic              ready;
	kind_t             kind;
	logic [7:0]        data;
	logic [CODE_W-1:0] code_value;
	status_t           status;
	logic [LEN_W-1:0]  payload_length;

	modport source (output valid, output kind, output data, output code_value,
		output status, output payload_length, input ready);
	modport sink (input valid, input kind, input data, input code_value,
		input status, input payload_length, output ready);
endinterface

FILE: sv/nsp_classify.sv
`timescale 1ns / 1ps

module nsp_classify (
	input  logic [7:0]           in_byte,
	output nsp_pkg::byte_class_t cls
);
	import nsp_pkg::*;

	always_comb begin
		cls.is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
		cls.is_colon = (in_byte == CH_COLON);
		cls.is_comma = (in_byte == CH_COMMA);
		cls.is_space = (in_byte == CH_SPACE);
		// For an ASCII digit the low nibble is its value.
		cls.digit    = in_byte[3:0];
	end
endmodule

FILE: sv/netstring_code_payload_parser.sv
`timescale 1ns / 1ps

// Channel  Dir  Beat payload                                           Handshake
// stream   in   in_byte[7:0], buffer_end                               valid/ready
// result   out  kind[1:0], data[7:0], code_value[63:0], status[2:0],   valid/ready
//               payload_length[29:0]
//
// One byte is taken every cycle while stream.ready is high; its result, if any,
// appears in the output register on the next cycle. Parser state and the
// output register update on the same edge, with no further stage in between.
// Reset puts the parser at the first length digit with no result pending.
// A new byte is accepted whenever the output register is empty or is being
// taken in the same cycle; a stall on result holds off stream only then.

module netstring_code_payload_parser (
	input  logic clk,
	input  logic arst_n,
	nsp_in_if.sink    stream,
	nsp_out_if.source result
);
	import nsp_pkg::*;

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_LEN,
		PH_CODE,
		PH_PAYLOAD,
		PH_SKIP
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [LEN_W-1:0]       len_acc_q, len_acc_d;
	logic [DIGIT_CNT_W-1:0] digit_cnt_q, digit_cnt_d;
	logic [CODE_W-1:0]      code_acc_q, code_acc_d;
	logic [LEN_W-1:0]       remain_q, remain_d;
	logic [LEN_W-1:0]       pay_cnt_q, pay_cnt_d;
	logic                   first_zero_q, first_zero_d;

	logic              out_valid_q;
	kind_t             out_kind_q, res_kind;
	logic [7:0]        out_data_q, res_data;
	logic [CODE_W-1:0] out_code_q, res_code;
	status_t           out_status_q, res_status;
	logic [LEN_W-1:0]  out_plen_q, res_plen;
	logic              res_valid;

	byte_class_t cls;
	logic        accept;
	logic        active, done;
	status_t     err;

	nsp_classify u_classify (
		.in_byte (stream.in_byte),
		.cls     (cls)
	);

	assign stream.ready = !out_valid_q || result.ready;
	assign accept       = stream.valid && stream.ready;

	always_comb begin
		phase_d      = phase_q;
		len_acc_d    = len_acc_q;
		digit_cnt_d  = digit_cnt_q;
		code_acc_d   = code_acc_q;
		remain_d     = remain_q;
		pay_cnt_d    = pay_cnt_q;
		first_zero_d = first_zero_q;
		res_valid    = 1'b0;
		res_kind     = KIND_BYTE;
		res_data     = '0;
		res_code     = '0;
		res_status   = ST_OK;
		res_plen     = '0;
		err          = ST_OK;
		done         = 1'b0;
		active       = 1'b1;

		unique case (phase_q)
			PH_FIRST: begin
				if (!cls.is_digit) begin
					err = ST_NO_LENGTH;
				end else begin
					len_acc_d    = LEN_W'(cls.digit);
					digit_cnt_d  = DIGIT_CNT_W'(1);
					first_zero_d = (cls.digit == 4'd0);
					phase_d      = PH_LEN;
				end
			end
			PH_LEN: begin
				if (cls.is_digit) begin
					if (first_zero_q) begin
						err = ST_LEAD_ZERO;
					end else if (digit_cnt_q >= DIGIT_CNT_W'(MAX_LEN_DIGITS)) begin
						err = ST_TOO_LONG;
					end else begin
						len_acc_d   = (len_acc_q << 3) + (len_acc_q << 1) + LEN_W'(cls.digit);
						digit_cnt_d = digit_cnt_q + DIGIT_CNT_W'(1);
					end
				end else if (cls.is_colon) begin
					remain_d   = len_acc_q;
					code_acc_d = '0;
					pay_cnt_d  = '0;
					phase_d    = PH_CODE;
				end else begin
					err = ST_NO_COLON;
				end
			end
			PH_CODE: begin
				if (remain_q == '0) begin
					if (cls.is_comma) begin
						done = 1'b1;
					end else begin
						err = ST_NO_COMMA;
					end
				end else if (cls.is_space) begin
					remain_d  = remain_q - LEN_W'(1);
					pay_cnt_d = '0;
					phase_d   = PH_PAYLOAD;
				end else if (cls.is_digit) begin
					code_acc_d = (code_acc_q << 3) + (code_acc_q << 1) + CODE_W'(cls.digit);
					remain_d   = remain_q - LEN_W'(1);
				end else begin
					err = ST_BAD_CODE;
				end
			end
			PH_PAYLOAD: begin
				if (remain_q == '0) begin
					if (cls.is_comma) begin
						done = 1'b1;
					end else begin
						err = ST_NO_COMMA;
					end
				end else begin
					remain_d  = remain_q - LEN_W'(1);
					pay_cnt_d = pay_cnt_q + LEN_W'(1);
					res_valid = 1'b1;
					res_data  = stream.in_byte;
				end
			end
			default: begin
				// Skipping after an error, and any unused phase code.
				active = 1'b0;
			end
		endcase

		if (err != ST_OK) begin
			res_valid  = 1'b1;
			res_kind   = KIND_ERR;
			res_data   = '0;
			res_status = err;
			phase_d    = PH_SKIP;
		end else if (done) begin
			res_valid    = 1'b1;
			res_kind     = KIND_DONE;
			res_code     = code_acc_q;
			res_plen     = (phase_q == PH_PAYLOAD) ? pay_cnt_q : '0;
			phase_d      = PH_FIRST;
			len_acc_d    = '0;
			digit_cnt_d  = '0;
			code_acc_d   = '0;
			remain_d     = '0;
			pay_cnt_d    = '0;
			first_zero_d = 1'b0;
		end else if (stream.buffer_end && active) begin
			// A record cut short; this replaces a payload byte on the same beat.
			res_valid  = 1'b1;
			res_kind   = KIND_ERR;
			res_data   = '0;
			res_status = ST_TOO_SHORT;
		end

		if (stream.buffer_end) begin
			phase_d      = PH_FIRST;
			len_acc_d    = '0;
			digit_cnt_d  = '0;
			code_acc_d   = '0;
			remain_d     = '0;
			pay_cnt_d    = '0;
			first_zero_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_FIRST;
			len_acc_q    <= '0;
			digit_cnt_q  <= '0;
			code_acc_q   <= '0;
			remain_q     <= '0;
			pay_cnt_q    <= '0;
			first_zero_q <= 1'b0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= KIND_BYTE;
			out_data_q   <= '0;
			out_code_q   <= '0;
			out_status_q <= ST_OK;
			out_plen_q   <= '0;
		end else begin
			if (accept) begin
				phase_q      <= phase_d;
				len_acc_q    <= len_acc_d;
				digit_cnt_q  <= digit_cnt_d;
				code_acc_q   <= code_acc_d;
				remain_q     <= remain_d;
				pay_cnt_q    <= pay_cnt_d;
				first_zero_q <= first_zero_d;
			end
			if (accept && res_valid) begin
				out_valid_q  <= 1'b1;
				out_kind_q   <= res_kind;
				out_data_q   <= res_data;
				out_code_q   <= res_code;
				out_status_q <= res_status;
				out_plen_q   <= res_plen;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.kind           = out_kind_q;
	assign result.data           = out_data_q;
	assign result.code_value     = out_code_q;
	assign result.status         = out_status_q;
	assign result.payload_length = out_plen_q;

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stream.buffer_end |=> phase_q == PH_FIRST)
		else $error("parser did not return to the first length digit after buffer end");

	a_err_status: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind == KIND_ERR |-> result.status != ST_OK)
		else $error("error beat carries an ok status");

	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind != KIND_ERR |-> result.status == ST_OK)
		else $error("non-error beat carries an error status");

	a_digit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		digit_cnt_q <= DIGIT_CNT_W'(MAX_LEN_DIGITS))
		else $error("length digit count ran past its limit");
endmodule
